// ===== rtl/pmms_pkg.sv =====
package pmms_pkg;

    // Field widths
    localparam int CMD_W   = 2;
    localparam int COMP_W  = 24;
    localparam int OUT_W   = 16;
    // Range may reach 1.0 at 24 fraction bits, so one extra bit
    localparam int RANGE_W = COMP_W + 1;
    // (v - min) * 65535 fits in component plus output width
    localparam int NUM_W   = COMP_W + OUT_W;

    localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

    // Request commands
    localparam logic [CMD_W-1:0] CMD_FIRST = 2'd0;
    localparam logic [CMD_W-1:0] CMD_MORE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_NORM  = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [COMP_W-1:0] red_in;
        logic [COMP_W-1:0] green_in;
        logic [COMP_W-1:0] blue_in;
    } pixel_t;

    typedef struct packed {
        logic [OUT_W-1:0] red_out;
        logic [OUT_W-1:0] green_out;
        logic [OUT_W-1:0] blue_out;
        logic [OUT_W-1:0] alpha_out;
    } stretch_t;

    // Divider status back to the sequencer
    typedef struct packed {
        logic             busy;
        logic             done;
        logic [OUT_W-1:0] quotient;
    } div_stat_t;

endpackage

// ===== rtl/pmms_divider.sv =====
module pmms_divider
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [pmms_pkg::NUM_W-1:0]    num,
    input  logic [pmms_pkg::RANGE_W-1:0]  den,
    output pmms_pkg::div_stat_t           stat
);
    import pmms_pkg::*;

    localparam int CNT_W = $clog2(OUT_W + 1);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(OUT_W);

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [COMP_W-1:0]    rem_reg;
    logic [OUT_W-1:0]     low_reg;    // dividend low bits, shifted out as quotient shifts in
    logic [RANGE_W-1:0]   den_reg;

    logic [RANGE_W:0]     trial;
    logic                 q_bit;
    logic                 ovf;

    // One restoring step: {rem, next dividend bit} - den
    assign trial = {1'b0, rem_reg, low_reg[OUT_W-1]} - {1'b0, den_reg};
    assign q_bit = ~trial[RANGE_W];
    // Quotient would exceed 16 bits: num >= den << 16
    assign ovf   = {1'b0, rem_reg} >= den_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                if (ovf)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
            end
            else if (cnt_reg == LAST_STEP)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num[NUM_W-1:OUT_W];
            low_reg <= num[OUT_W-1:0];
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                if (ovf)
                begin
                    low_reg <= OUT_MAX;
                end
            end
            else
            begin
                if (q_bit)
                begin
                    rem_reg <= trial[COMP_W-1:0];
                end
                else
                begin
                    rem_reg <= {rem_reg[COMP_W-2:0], low_reg[OUT_W-1]};
                end
                low_reg <= {low_reg[OUT_W-2:0], q_bit};
            end
        end
    end

    assign stat.busy     = busy_reg;
    assign stat.done     = done_reg;
    assign stat.quotient = low_reg;

endmodule

// ===== rtl/per_channel_min_max_stretch_unit.sv =====
// Channel    Direction  Handshake                    Payload
// pixel      in         pixel_valid / pixel_ready    pmms_pkg::pixel_t   (cmd, R, G, B)
// stretched  out        stretched_valid / _ready     pmms_pkg::stretch_t (R, G, B, alpha)
//
// Stats requests (cmd 0, 1) update min/max in the accept cycle; ready stays high.
// A normalize request (cmd 2) runs three channels in turn through one restoring divider,
// each through load, start, overflow check, the quotient bits and capture, with the quotient
// bits skipped when the quotient clamps. The result is registered once the output is free.
// Ready is low meanwhile, and also while a finished result waits for a stalled output.
// Reset clears min/max to zero and the sequencer to idle; cmd 3 is dropped.
module per_channel_min_max_stretch_unit
#(
    parameter int FRACTION_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pixel_valid,
    output logic               pixel_ready,
    input  pmms_pkg::pixel_t   pixel,
    output logic               stretched_valid,
    input  logic               stretched_ready,
    output pmms_pkg::stretch_t stretched
);
    import pmms_pkg::*;

    // 1.0 in component fixed point; minimum divisor
    localparam logic [RANGE_W-1:0] RangeOne = {{(RANGE_W-1){1'b0}}, 1'b1} << FRACTION_BITS;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_LOAD  = 2'd1;
    localparam logic [1:0] S_START = 2'd2;
    localparam logic [1:0] S_DIV   = 2'd3;

    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [1:0]          ch_reg, ch_next;
    logic                done_pend_reg, done_pend_next;   // all three quotients ready

    // Running statistics, order R, G, B
    logic [COMP_W-1:0]   min_reg [3];
    logic [COMP_W-1:0]   max_reg [3];

    pixel_t              pix_reg;
    logic [COMP_W-1:0]   d_reg;       // v - min, or 0
    logic [RANGE_W-1:0]  range_reg;
    logic [OUT_W-1:0]    res_reg [3];

    logic                out_valid_reg;
    stretch_t            out_reg;

    logic                accept;
    logic                out_free;
    logic [COMP_W-1:0]   v_sel, lo_sel, hi_sel;
    logic [RANGE_W-1:0]  range_raw;
    logic [NUM_W-1:0]    num;
    logic                div_start;
    div_stat_t           div_stat;

    assign accept   = pixel_valid && pixel_ready;
    assign out_free = !out_valid_reg || stretched_ready;

    // Channel mux into the shared datapath
    always_comb
    begin
        unique case (ch_reg)
            CH_RED:
            begin
                v_sel  = pix_reg.red_in;
                lo_sel = min_reg[0];
                hi_sel = max_reg[0];
            end
            CH_GREEN:
            begin
                v_sel  = pix_reg.green_in;
                lo_sel = min_reg[1];
                hi_sel = max_reg[1];
            end
            CH_BLUE:
            begin
                v_sel  = pix_reg.blue_in;
                lo_sel = min_reg[2];
                hi_sel = max_reg[2];
            end
            default:
            begin
                v_sel  = '0;
                lo_sel = '0;
                hi_sel = '0;
            end
        endcase
    end

    assign range_raw = (hi_sel > lo_sel) ? {1'b0, hi_sel - lo_sel} : '0;

    // (v - min) * 65535 as (d << 16) - d
    assign num = {d_reg, {OUT_W{1'b0}}} - {{OUT_W{1'b0}}, d_reg};

    assign div_start = (state_reg == S_START);

    pmms_divider u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num),
        .den   (range_reg),
        .stat  (div_stat)
    );

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        ch_next        = ch_reg;
        done_pend_next = done_pend_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (done_pend_reg)
                begin
                    if (out_free)
                    begin
                        done_pend_next = 1'b0;
                    end
                end
                else if (accept && pixel.cmd == CMD_NORM)
                begin
                    ch_next    = CH_RED;
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                state_next = S_START;
            end
            S_START:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    if (ch_reg == CH_BLUE)
                    begin
                        done_pend_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        ch_next    = ch_reg + 2'd1;
                        state_next = S_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Input closed while the divider runs and while a finished result waits for the output
    assign pixel_ready = (state_reg == S_IDLE) && !done_pend_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ch_reg        <= CH_RED;
            done_pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                min_reg[i] <= '0;
                max_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            ch_reg        <= ch_next;
            done_pend_reg <= done_pend_next;

            if (done_pend_reg && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (stretched_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (accept)
            begin
                if (pixel.cmd == CMD_FIRST)
                begin
                    min_reg[0] <= pixel.red_in;
                    min_reg[1] <= pixel.green_in;
                    min_reg[2] <= pixel.blue_in;
                    max_reg[0] <= pixel.red_in;
                    max_reg[1] <= pixel.green_in;
                    max_reg[2] <= pixel.blue_in;
                end
                else if (pixel.cmd == CMD_MORE)
                begin
                    if (pixel.red_in < min_reg[0])   min_reg[0] <= pixel.red_in;
                    if (pixel.green_in < min_reg[1]) min_reg[1] <= pixel.green_in;
                    if (pixel.blue_in < min_reg[2])  min_reg[2] <= pixel.blue_in;
                    if (pixel.red_in > max_reg[0])   max_reg[0] <= pixel.red_in;
                    if (pixel.green_in > max_reg[1]) max_reg[1] <= pixel.green_in;
                    if (pixel.blue_in > max_reg[2])  max_reg[2] <= pixel.blue_in;
                end
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (accept && pixel.cmd == CMD_NORM)
        begin
            pix_reg <= pixel;
        end

        if (state_reg == S_LOAD)
        begin
            d_reg     <= (v_sel > lo_sel) ? (v_sel - lo_sel) : '0;
            range_reg <= (range_raw < RangeOne) ? RangeOne : range_raw;
        end

        if (state_reg == S_DIV && div_stat.done)
        begin
            unique case (ch_reg)
                CH_RED:   res_reg[0] <= div_stat.quotient;
                CH_GREEN: res_reg[1] <= div_stat.quotient;
                CH_BLUE:  res_reg[2] <= div_stat.quotient;
                default:  ;
            endcase
        end

        if (done_pend_reg && out_free)
        begin
            out_reg.red_out   <= res_reg[0];
            out_reg.green_out <= res_reg[1];
            out_reg.blue_out  <= res_reg[2];
            out_reg.alpha_out <= OUT_MAX;
        end
    end

    assign stretched_valid = out_valid_reg;
    assign stretched       = out_reg;

endmodule

// ===== rtl/pmms_checker.sv =====
module pmms_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               pixel_valid,
    input logic               pixel_ready,
    input pmms_pkg::pixel_t   pixel,
    input logic               stretched_valid,
    input logic               stretched_ready,
    input pmms_pkg::stretch_t stretched
);
    import pmms_pkg::*;

    // Alpha is fixed full scale
    a_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        stretched_valid |-> stretched.alpha_out == OUT_MAX)
        else $error("alpha not full scale");

    // Stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        stretched_valid && !stretched_ready |=> stretched_valid && $stable(stretched))
        else $error("stalled result changed");

    // Stats requests never stall the input
    a_stats: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && pixel_ready && (pixel.cmd == CMD_FIRST || pixel.cmd == CMD_MORE)
        |=> pixel_ready)
        else $error("ready dropped after stats request");

    // Normalize occupies the divider: input closed next cycle, no instant result
    a_norm: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && pixel_ready && pixel.cmd == CMD_NORM
        |=> !pixel_ready ##1 !pixel_ready)
        else $error("input reopened during normalize");

endmodule

bind per_channel_min_max_stretch_unit pmms_checker u_pmms_checker
(
    .clk             (clk),
    .rst_n           (rst_n),
    .pixel_valid     (pixel_valid),
    .pixel_ready     (pixel_ready),
    .pixel           (pixel),
    .stretched_valid (stretched_valid),
    .stretched_ready (stretched_ready),
    .stretched       (stretched)
);
